FILE: rtl/core/wmvs_pkg.sv
// shared types, codes and defaults for the windowed mean / variance / stddev block
// no dependencies; imported by windowed_mean_variance_stddev
package wmvs_pkg;

    // default sizing of the accumulators
    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int SAMPLE_BITS_DEF = 16;

    // fixed field widths
    localparam int TIME_W   = 32;
    localparam int VALUE_W  = 16;
    localparam int WINDOW_W = 16;
    localparam int BIN_W    = 32;
    localparam int COUNT_W  = 13;
    localparam int MEAN_W   = 16;
    localparam int VAR_W    = 32;
    localparam int SQRT_W   = 16;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd60;
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;
    localparam logic [VAR_W-1:0]    VAR_MAX      = '1;

    // input word codes
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    // result word codes
    localparam logic STATUS_STATS = 1'b0;
    localparam logic STATUS_LATE  = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [TIME_W-1:0]  time_seconds;
        logic [VALUE_W-1:0] sample_value;
    } t_sample;

    typedef struct packed {
        logic               status;
        logic [BIN_W-1:0]   bin_index;
        logic [COUNT_W-1:0] sample_count;
        logic [MEAN_W-1:0]  mean_value;
        logic [VAR_W-1:0]   variance_value;
        logic [SQRT_W-1:0]  std_deviation;
        logic               overflowed;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TDIV,
        ST_DECIDE,
        ST_OPEN,
        ST_ACC,
        ST_SDIV,
        ST_SDONE,
        ST_MQQN,
        ST_MQR,
        ST_DIFF,
        ST_VDIV,
        ST_VDONE,
        ST_MRR,
        ST_FIX,
        ST_SQRT,
        ST_EMIT
    } t_state;

endpackage

FILE: rtl/core/windowed_mean_variance_stddev.sv
// Windowed mean, sample variance and standard deviation of time-stamped samples.
// One word is taken at a time. A sample runs a 32-step restoring division of its
// time by the window (one quotient bit per cycle) before the next word is taken.
// Closing a bin (flush or a sample for a later bin) adds the SW-step sum division,
// the QW-step variance division and a 16-step square root (for a bin of one sample
// only the sum division), plus any wait for the output register, with
// SW = VB + CW and QW = 2*VB + CW, VB = min(SAMPLE_BITS, 16) and
// CW = clog2(MAX_SAMPLES_PER_BIN + 1). The divisions and the square root all run on
// one shared subtract/compare unit, with one shared multiplier for the squares and
// correction products. The result word sits in an output register, so the block
// goes on with a new word while it waits.
// Depends on wmvs_pkg.
module windowed_mean_variance_stddev
    import wmvs_pkg::*;
#(
    parameter int MAX_SAMPLES_PER_BIN = MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS         = SAMPLE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [WINDOW_W-1:0] i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_sample             i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_result             o_out_data
);

    localparam int VB   = (SAMPLE_BITS < VALUE_W) ? SAMPLE_BITS : VALUE_W;
    localparam int CW   = $clog2(MAX_SAMPLES_PER_BIN + 1);
    localparam int SW   = VB + CW;
    localparam int QW   = 2 * VB + CW;
    localparam int DVW  = (QW > TIME_W) ? QW : TIME_W;
    localparam int DDW  = (CW > WINDOW_W) ? CW : WINDOW_W;
    localparam int UW   = (DDW + 1 > 19) ? DDW + 1 : 19;
    localparam int MAW  = (2 * VB > CW) ? 2 * VB : CW;
    localparam int MBW  = (VB > CW) ? VB : CW;
    localparam int PW   = MAW + MBW;
    localparam int AW   = (QW > VAR_W) ? QW : VAR_W;
    localparam int CXW  = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int CNTW = $clog2(DVW + 1);

    t_state r_state, n_state;

    // bin accumulators
    logic              r_active;
    logic [BIN_W-1:0]  r_open_bin;
    logic [CW-1:0]     r_count;
    logic [SW-1:0]     r_sum;
    logic [QW-1:0]     r_sq;
    logic              r_ovf;
    logic [WINDOW_W-1:0] r_window;

    // working registers
    logic [VB-1:0]     r_v;
    logic [BIN_W-1:0]  r_new_bin;
    logic              r_late;
    logic              r_reopen;
    logic [DVW-1:0]    r_quo;
    logic [UW-1:0]     r_rem;
    logic [DDW-1:0]    r_den;
    logic [CNTW-1:0]   r_cnt;
    logic [SQRT_W-1:0] r_root;
    logic [VB-1:0]     r_mean;
    logic [CW-1:0]     r_r;
    logic [PW-1:0]     r_t1;
    logic [PW-1:0]     r_t2;
    logic [QW-1:0]     r_a;
    logic [VAR_W-1:0]  r_var;

    logic              r_out_valid;
    t_result           r_out;

    logic              w_in_acc;
    logic              w_ld_tdiv;
    logic              w_ld_sdiv;
    logic              w_emit;
    logic              w_last;
    logic [MAW-1:0]    w_mul_a;
    logic [MBW-1:0]    w_mul_b;
    logic [PW-1:0]     w_prod;
    logic [UW-1:0]     w_sub_a;
    logic [UW-1:0]     w_sub_b;
    logic [UW:0]       w_diff;
    logic              w_borrow;
    logic [WINDOW_W-1:0] w_win;
    logic [BIN_W-1:0]  w_bin;
    logic [QW-1:0]     w_d;
    logic [QW-1:0]     w_afix;
    logic [AW-1:0]     w_aext;
    logic [VAR_W-1:0]  w_var;
    logic [CXW-1:0]    w_cext;
    logic [COUNT_W-1:0] w_cnt_out;

    assign w_in_acc = i_in_valid && o_in_ready;
    assign w_last   = (r_cnt == CNTW'(1));
    assign w_win    = (r_window == '0) ? WINDOW_W'(1) : r_window;
    assign w_bin    = r_quo[BIN_W-1:0];

    // shared multiplier and shared subtractor
    assign w_prod   = w_mul_a * w_mul_b;
    assign w_diff   = {1'b0, w_sub_a} - {1'b0, w_sub_b};
    assign w_borrow = w_diff[UW];

    // d = sq - q*q*n - 2*q*r, exact in QW bits
    assign w_d    = r_sq - QW'(r_t1) - QW'({r_t2, 1'b0});
    assign w_afix = (r_t1 < r_t2) ? (r_a - QW'(1)) : r_a;
    assign w_aext = AW'(w_afix);
    assign w_var  = (w_aext > AW'(VAR_MAX)) ? VAR_MAX : w_aext[VAR_W-1:0];
    assign w_cext = CXW'(r_count);
    assign w_cnt_out = (w_cext > CXW'(COUNT_MAX)) ? COUNT_MAX : w_cext[COUNT_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_in_data.kind == KIND_SAMPLE) begin
                        n_state = ST_TDIV;
                    end else if (r_active) begin
                        n_state = ST_SDIV;
                    end
                end
            end
            ST_TDIV:   if (w_last) n_state = ST_DECIDE;
            ST_DECIDE: begin
                priority if (!r_active) begin
                    n_state = ST_OPEN;
                end else if (w_bin == r_open_bin) begin
                    n_state = (r_count >= CW'(MAX_SAMPLES_PER_BIN)) ? ST_IDLE : ST_ACC;
                end else if (w_bin > r_open_bin) begin
                    n_state = ST_SDIV;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_OPEN:   n_state = ST_IDLE;
            ST_ACC:    n_state = ST_IDLE;
            ST_SDIV:   if (w_last) n_state = ST_SDONE;
            ST_SDONE:  n_state = (r_count <= CW'(1)) ? ST_EMIT : ST_MQQN;
            ST_MQQN:   n_state = ST_MQR;
            ST_MQR:    n_state = ST_DIFF;
            ST_DIFF:   n_state = ST_VDIV;
            ST_VDIV:   if (w_last) n_state = ST_VDONE;
            ST_VDONE:  n_state = ST_MRR;
            ST_MRR:    n_state = ST_FIX;
            ST_FIX:    n_state = ST_SQRT;
            ST_SQRT:   if (w_last) n_state = ST_EMIT;
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = (r_reopen && !r_late) ? ST_OPEN : ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // control and operand selection
    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        w_ld_tdiv  = (r_state == ST_IDLE) && (n_state == ST_TDIV);
        w_ld_sdiv  = (r_state != ST_SDIV) && (n_state == ST_SDIV);
        w_emit     = (r_state == ST_EMIT) && (!r_out_valid || i_out_ready);
        w_mul_a    = '0;
        w_mul_b    = '0;
        unique case (r_state)
            ST_OPEN, ST_ACC: begin
                w_mul_a = MAW'(r_v);
                w_mul_b = MBW'(r_v);
            end
            ST_SDONE: begin
                w_mul_a = MAW'(r_quo[VB-1:0]);
                w_mul_b = MBW'(r_quo[VB-1:0]);
            end
            ST_MQQN: begin
                w_mul_a = MAW'(r_t1[2*VB-1:0]);
                w_mul_b = MBW'(r_count);
            end
            ST_MQR: begin
                w_mul_a = MAW'(r_mean);
                w_mul_b = MBW'(r_r);
            end
            ST_VDONE: begin
                w_mul_a = MAW'(r_count);
                w_mul_b = MBW'(r_rem[CW-1:0]);
            end
            ST_MRR: begin
                w_mul_a = MAW'(r_r);
                w_mul_b = MBW'(r_r);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
        if (r_state == ST_SQRT) begin
            w_sub_a = UW'({r_rem[UW-3:0], r_quo[DVW-1:DVW-2]});
            w_sub_b = UW'({r_root, 2'b01});
        end else begin
            w_sub_a = UW'({r_rem[DDW-1:0], r_quo[DVW-1]});
            w_sub_b = UW'(r_den);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_window    <= WINDOW_RESET;
            r_active    <= 1'b0;
            r_open_bin  <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_sq        <= '0;
            r_ovf       <= 1'b0;
            r_late      <= 1'b0;
            r_reopen    <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_window <= i_cfg_data;
            end
            if (w_in_acc) begin
                r_late   <= 1'b0;
                r_reopen <= 1'b0;
            end
            if (w_ld_tdiv) begin
                r_cnt <= CNTW'(TIME_W);
            end else if (w_ld_sdiv) begin
                r_cnt <= CNTW'(SW);
            end else if (r_state == ST_DIFF) begin
                r_cnt <= CNTW'(QW);
            end else if (r_state == ST_FIX) begin
                r_cnt <= CNTW'(SQRT_W);
            end else if (r_state == ST_TDIV || r_state == ST_SDIV ||
                         r_state == ST_VDIV || r_state == ST_SQRT) begin
                r_cnt <= r_cnt - CNTW'(1);
            end
            if (r_state == ST_DECIDE && r_active && w_bin != r_open_bin) begin
                r_reopen <= (w_bin > r_open_bin);
                r_late   <= (w_bin < r_open_bin);
            end
            if (r_state == ST_DECIDE && r_active && w_bin == r_open_bin &&
                r_count >= CW'(MAX_SAMPLES_PER_BIN)) begin
                r_ovf <= 1'b1;
            end
            if (r_state == ST_OPEN) begin
                r_active   <= 1'b1;
                r_open_bin <= r_new_bin;
                r_count    <= CW'(1);
                r_sum      <= SW'(r_v);
                r_sq       <= QW'(w_prod);
                r_ovf      <= 1'b0;
            end
            if (r_state == ST_ACC) begin
                r_count <= r_count + CW'(1);
                r_sum   <= r_sum + SW'(r_v);
                r_sq    <= r_sq + QW'(w_prod);
            end
            // flush closes the bin as its word is loaded into the output register
            if (w_emit && !r_late && !r_reopen) begin
                r_active <= 1'b0;
                r_count  <= '0;
                r_sum    <= '0;
                r_sq     <= '0;
                r_ovf    <= 1'b0;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_v <= i_in_data.sample_value[VB-1:0];
        end
        if (r_state == ST_DECIDE) begin
            r_new_bin <= w_bin;
        end
        if (w_ld_tdiv) begin
            r_quo <= DVW'(i_in_data.time_seconds) << (DVW - TIME_W);
            r_rem <= '0;
            r_den <= DDW'(w_win);
        end else if (w_ld_sdiv) begin
            r_quo <= DVW'(r_sum) << (DVW - SW);
            r_rem <= '0;
            r_den <= DDW'(r_count);
        end else begin
            unique case (r_state)
                ST_TDIV, ST_SDIV, ST_VDIV: begin
                    // restoring divide, one quotient bit per cycle
                    r_quo <= {r_quo[DVW-2:0], !w_borrow};
                    r_rem <= w_borrow ? w_sub_a : w_diff[UW-1:0];
                end
                ST_SQRT: begin
                    r_quo  <= {r_quo[DVW-3:0], 2'b00};
                    r_rem  <= w_borrow ? w_sub_a : w_diff[UW-1:0];
                    r_root <= {r_root[SQRT_W-2:0], !w_borrow};
                end
                ST_SDONE: begin
                    r_mean <= r_quo[VB-1:0];
                    r_r    <= r_rem[CW-1:0];
                    r_t1   <= w_prod;
                    r_var  <= '0;
                    r_root <= '0;
                end
                ST_MQQN: begin
                    r_t1 <= w_prod;
                end
                ST_MQR: begin
                    r_t2 <= w_prod;
                end
                ST_DIFF: begin
                    r_quo <= DVW'(w_d) << (DVW - QW);
                    r_rem <= '0;
                    r_den <= DDW'(r_count - CW'(1));
                end
                ST_VDONE: begin
                    r_a  <= r_quo[QW-1:0];
                    r_t1 <= w_prod;
                end
                ST_MRR: begin
                    r_t2 <= w_prod;
                end
                ST_FIX: begin
                    r_var  <= w_var;
                    r_quo  <= DVW'(w_var) << (DVW - VAR_W);
                    r_rem  <= '0;
                    r_root <= '0;
                end
                default: begin
                end
            endcase
        end
        if (w_emit) begin
            if (r_late) begin
                r_out.status         <= STATUS_LATE;
                r_out.bin_index      <= r_new_bin;
                r_out.sample_count   <= '0;
                r_out.mean_value     <= '0;
                r_out.variance_value <= '0;
                r_out.std_deviation  <= '0;
                r_out.overflowed     <= 1'b0;
            end else begin
                r_out.status         <= STATUS_STATS;
                r_out.bin_index      <= r_open_bin;
                r_out.sample_count   <= w_cnt_out;
                r_out.mean_value     <= MEAN_W'(r_mean);
                r_out.variance_value <= r_var;
                r_out.std_deviation  <= r_root;
                r_out.overflowed     <= r_ovf;
            end
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // an open bin always holds at least one sample
    a_active_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active == (r_count != '0))
        else $error("bin active flag and sample count disagree");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SAMPLES_PER_BIN))
        else $error("sample count beyond per-bin limit");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_count == CW'(MAX_SAMPLES_PER_BIN)))
        else $error("overflow flagged on a bin that is not full");

    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_data.kind == KIND_SAMPLE) |=> !o_in_ready)
        else $error("ready while a sample word is being divided");

    // the root handed out is the floor square root of the variance
    a_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && !r_late) |->
            ((33'(r_root) * 33'(r_root) <= 33'(r_var)) &&
             (33'(r_var) < (33'(r_root) + 33'd1) * (33'(r_root) + 33'd1))))
        else $error("square root out of range");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for windowed_mean_variance_stddev: a directed table, then random phases
// under several window settings and idling patterns, checked against an in-bench bin predictor
// depends on wmvs_pkg and the windowed_mean_variance_stddev rtl
module testbench;
    import wmvs_pkg::*;

    localparam int     MAX_PER_BIN    = MAX_SAMPLES_DEF;
    localparam int     SETTLE_CYCLES  = 300;
    localparam longint TIMEOUT_CYCLES = 3000000;

    typedef enum {NO_IDLE, SENDER_IDLE, RECEIVER_STALL, BOTH_IDLE} t_idling;

    typedef struct {
        t_sample word;
        bit      typed;
        t_result want;
    } t_row;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [WINDOW_W-1:0] cfg_data  = '0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    t_sample             in_word   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    t_result             out_word;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    longint      cycle_count    = 0;
    bit          failed         = 1'b0;
    t_result     pending_stats[$];

    // predictor state
    logic [WINDOW_W-1:0] window_reg = WINDOW_RESET;
    bit [BIN_W-1:0]      cur_bin    = '0;
    bit                  bin_open   = 1'b0;
    int unsigned         bin_count  = 0;
    longint unsigned     bin_sum    = 0;
    longint unsigned     bin_sqsum  = 0;
    bit                  bin_dropped = 1'b0;

    windowed_mean_variance_stddev dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_word)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic bit [SQRT_W-1:0] floor_root(input bit [VAR_W-1:0] v);
        bit [31:0] root;
        bit [31:0] trial;
        root = '0;
        for (int b = SQRT_W - 1; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (64'(trial) * 64'(trial) <= 64'(v)) root = trial;
        end
        return root[SQRT_W-1:0];
    endfunction

    function automatic t_result bin_statistics();
        t_result         r;
        bit [127:0]      spread;
        bit [127:0]      pairs;
        bit [127:0]      variance;
        longint unsigned mean;
        r = '0;
        r.status    = STATUS_STATS;
        r.bin_index = cur_bin;
        r.sample_count = (bin_count > 8191) ? COUNT_MAX : COUNT_W'(bin_count);
        mean = (bin_count != 0) ? bin_sum / bin_count : 0;
        r.mean_value = (mean > 64'hFFFF) ? 16'hFFFF : MEAN_W'(mean);
        variance = '0;
        if (bin_count > 1) begin
            // exact n*sumsq - sum^2 over n*(n-1)
            spread   = 128'(bin_count) * bin_sqsum - 128'(bin_sum) * bin_sum;
            pairs    = 128'(bin_count) * (bin_count - 1);
            variance = spread / pairs;
        end
        r.variance_value = (variance > 128'(VAR_MAX)) ? VAR_MAX : VAR_W'(variance);
        r.std_deviation  = floor_root(r.variance_value);
        r.overflowed     = bin_dropped;
        return r;
    endfunction

    function automatic void open_new_bin(input bit [BIN_W-1:0] bin, input longint unsigned v);
        cur_bin     = bin;
        bin_open    = 1'b1;
        bin_count   = 1;
        bin_sum     = v;
        bin_sqsum   = v * v;
        bin_dropped = 1'b0;
    endfunction

    // returns 1 when the word produces a result word
    function automatic bit predict_word(input t_sample w, output t_result r);
        bit [WINDOW_W-1:0] win;
        bit [BIN_W-1:0]    bin;
        longint unsigned   v;
        win = (window_reg == 0) ? WINDOW_W'(1) : window_reg;
        bin = w.time_seconds / win;
        v   = w.sample_value;
        r   = '0;
        if (w.kind == KIND_FLUSH) begin
            if (!bin_open) return 1'b0;
            r = bin_statistics();
            bin_open    = 1'b0;
            bin_count   = 0;
            bin_sum     = 0;
            bin_sqsum   = 0;
            bin_dropped = 1'b0;
            return 1'b1;
        end
        if (!bin_open) begin
            open_new_bin(bin, v);
            return 1'b0;
        end
        if (bin == cur_bin) begin
            if (bin_count >= MAX_PER_BIN) begin
                bin_dropped = 1'b1;
            end else begin
                bin_count++;
                bin_sum   += v;
                bin_sqsum += v * v;
            end
            return 1'b0;
        end
        if (bin > cur_bin) begin
            r = bin_statistics();
            open_new_bin(bin, v);
            return 1'b1;
        end
        r.status    = STATUS_LATE;
        r.bin_index = bin;
        return 1'b1;
    endfunction

    function automatic t_sample sample_word(input bit [TIME_W-1:0] t, input bit [VALUE_W-1:0] v);
        t_sample w;
        w.kind         = KIND_SAMPLE;
        w.time_seconds = t;
        w.sample_value = v;
        return w;
    endfunction

    function automatic t_sample flush_word();
        t_sample w;
        w = '0;
        w.kind = KIND_FLUSH;
        return w;
    endfunction

    function automatic t_result single_stats(input bit [BIN_W-1:0] bin,
                                             input bit [MEAN_W-1:0] mean);
        t_result r;
        r = '0;
        r.status       = STATUS_STATS;
        r.bin_index    = bin;
        r.sample_count = COUNT_W'(1);
        r.mean_value   = mean;
        return r;
    endfunction

    function automatic t_result late_drop(input bit [BIN_W-1:0] bin);
        t_result r;
        r = '0;
        r.status    = STATUS_LATE;
        r.bin_index = bin;
        return r;
    endfunction

    function automatic bit [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            // tight cluster gives small variances
            2: return VALUE_W'(16'h4000 + $urandom_range(0, 15));
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            failed = 1'b1;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk) begin
        t_result want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_stats.size() == 0) begin
                failed = 1'b1;
                $display("%0t: result word with nothing expected, expected none got %p",
                         $time, out_word);
            end else begin
                want = pending_stats.pop_front();
                check_field("status", want.status, out_word.status);
                check_field("bin_index", want.bin_index, out_word.bin_index);
                check_field("sample_count", want.sample_count, out_word.sample_count);
                check_field("mean_value", want.mean_value, out_word.mean_value);
                check_field("variance_value", want.variance_value, out_word.variance_value);
                check_field("std_deviation", want.std_deviation, out_word.std_deviation);
                check_field("overflowed", want.overflowed, out_word.overflowed);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(negedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic void set_idling(input t_idling mode);
        send_idle_pct  = (mode == SENDER_IDLE) ? 87 : (mode == BOTH_IDLE) ? 38 : 0;
        recv_stall_pct = (mode == RECEIVER_STALL) ? 87 : (mode == BOTH_IDLE) ? 38 : 0;
    endfunction

    task automatic send_word(input t_sample w, input bit typed, input t_result want);
        t_result predicted;
        bit      has_result;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        has_result = predict_word(w, predicted);
        if (typed) pending_stats = {pending_stats, want};
        else if (has_result) pending_stats = {pending_stats, predicted};
    endtask

    // drain results, then give a word with no result time to finish
    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input bit [WINDOW_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        window_reg = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly time-ordered streams, with some flushes, late samples and stray times
    task automatic random_phase(input int n_words);
        longint unsigned win;
        longint unsigned now;
        longint unsigned t;
        longint unsigned step;
        int              pick;
        t_sample         w;
        send_word(flush_word(), 1'b0, '0);
        now = $urandom;
        for (int i = 0; i < n_words; i++) begin
            win  = (window_reg == 0) ? 1 : window_reg;
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                w = flush_word();
            end else begin
                if (pick < 10) begin
                    t = (now > 2 * win) ? now - win * $urandom_range(1, 2) : 0;
                end else if (pick < 13) begin
                    t = $urandom;
                end else begin
                    case ($urandom_range(0, 19))
                        0:          step = win * $urandom_range(1, 5);
                        1, 2, 3, 4: step = $urandom_range(0, 32'(win));
                        default:    step = $urandom_range(0, 32'(win / 8));
                    endcase
                    now += step;
                    if (now > 64'hFFFF_FFFF) now = 64'hFFFF_FFFF;
                    t = now;
                end
                w = sample_word(TIME_W'(t), random_value());
            end
            send_word(w, 1'b0, '0);
        end
    endtask

    initial begin
        t_row directed_rows [19];
        directed_rows = '{
            '{flush_word(),                         1'b0, t_result'(0)},
            '{sample_word(32'd0, 16'h0000),         1'b0, t_result'(0)},
            '{flush_word(),                         1'b1, single_stats(32'd0, 16'h0000)},
            '{sample_word(32'hFFFF_FFFF, 16'hFFFF), 1'b0, t_result'(0)},
            '{flush_word(),                         1'b1, single_stats(32'd71582788, 16'hFFFF)},
            '{sample_word(32'd120, 16'hFFFF),       1'b0, t_result'(0)},
            '{sample_word(32'd179, 16'h0000),       1'b0, t_result'(0)},
            '{sample_word(32'd100, 16'h1234),       1'b1, late_drop(32'd1)},
            '{sample_word(32'd180, 16'h8000),       1'b0, t_result'(0)},
            '{sample_word(32'd181, 16'h8001),       1'b0, t_result'(0)},
            '{sample_word(32'd239, 16'h7FFF),       1'b0, t_result'(0)},
            '{sample_word(32'd240, 16'h0100),       1'b0, t_result'(0)},
            '{sample_word(32'd6000, 16'hA5A5),      1'b1, single_stats(32'd4, 16'h0100)},
            '{sample_word(32'd0, 16'h5A5A),         1'b1, late_drop(32'd0)},
            '{flush_word(),                         1'b1, single_stats(32'd100, 16'hA5A5)},
            '{flush_word(),                         1'b0, t_result'(0)},
            '{sample_word(32'd59, 16'h00FF),        1'b0, t_result'(0)},
            '{sample_word(32'd59, 16'hFF00),        1'b0, t_result'(0)},
            '{flush_word(),                         1'b0, t_result'(0)}
        };

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_idling(NO_IDLE);
        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

        quiesce();
        write_window(16'd1);
        set_idling(SENDER_IDLE);
        random_phase(250);

        quiesce();
        write_window(16'hFFFF);
        set_idling(RECEIVER_STALL);
        random_phase(250);

        // zero window behaves as one second
        quiesce();
        write_window(16'd0);
        set_idling(BOTH_IDLE);
        random_phase(250);

        quiesce();
        write_window(WINDOW_W'($urandom_range(1, 65535)));
        set_idling(NO_IDLE);
        random_phase(200);

        quiesce();
        write_window(WINDOW_W'($urandom_range(2, 300)));
        set_idling(BOTH_IDLE);
        random_phase(200);

        quiesce();
        write_window(WINDOW_RESET);
        set_idling(SENDER_IDLE);
        random_phase(200);

        quiesce();
        if (!failed) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
